// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ULT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ULT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ULT_ASSERT(lbl, clk, rst, prop, msg)

`define ULT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/ult_pkg.sv =====
// types, widths and codes of the unordered list table
`default_nettype none

package ult_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W = 32;
  localparam int POS_W = 7;
  localparam int ENTRY_COUNT_W = 8;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = CNT_W + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } seq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ult_if.sv =====
// request and result channel interfaces
`default_nettype none

interface ult_req_if;
  logic                      valid;
  logic                      ready;
  ult_pkg::op_t              operation;
  logic signed [31:0]        key;
  logic signed [31:0]        new_value;

  modport source (output valid, output operation, output key, output new_value, input ready);
  modport sink (input valid, input operation, input key, input new_value, output ready);
endinterface

interface ult_res_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     found;
  logic [ult_pkg::POS_W-1:0]                position;
  logic [ult_pkg::ENTRY_COUNT_W-1:0]        entry_count;
  ult_pkg::status_t                         status;

  modport source (output valid, output found, output position, output entry_count,
                  output status, input ready);
  modport sink (input valid, input found, input position, input entry_count,
                input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/ult_store.sv =====
// entry memory, one write port and one registered read port
`default_nettype none

module ult_store (
  input  wire logic                       clk,
  input  wire ult_pkg::mem_req_t          mem_req,
  output logic [ult_pkg::DATA_W-1:0]      rd_data
);
  import ult_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rd_data <= mem[mem_req.raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ult_seq.sv =====
// sequencer with the shared key comparator and the result register
`default_nettype none

module ult_seq (
  input  wire logic                    clk,
  input  wire logic                    rst,
  ult_req_if.sink                      request,
  ult_res_if.source                    result,
  input  wire logic [ult_pkg::DATA_W-1:0] rd_data,
  output ult_pkg::mem_req_t            mem_req,
  output ult_pkg::seq_stat_t           stat
);
  import ult_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN_RD  = 6'b000010,
    S_SCAN_CMP = 6'b000100,
    S_SHIFT_RD = 6'b001000,
    S_SHIFT_WR = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  op_t               op_reg;
  logic [DATA_W-1:0] key_reg;
  logic [DATA_W-1:0] nv_reg;
  logic              res_found;
  logic [IDX_W-1:0]  res_pos;
  status_t           res_status;

  logic              out_valid;
  logic              out_found;
  logic [POS_W-1:0]  out_pos;
  logic [ENTRY_COUNT_W-1:0] out_count;
  status_t           out_status;

  logic accept;
  logic has_room;
  logic match;
  logic [CMP_W-1:0] idx_plus1;
  logic [CMP_W-1:0] idx_plus2;
  logic [CMP_W-1:0] count_ext;

  assign accept    = request.valid && request.ready;
  assign has_room  = count < CNT_W'(CAPACITY);
  assign match     = rd_data == key_reg;
  assign idx_plus1 = CMP_W'(idx) + CMP_W'(1);
  assign idx_plus2 = CMP_W'(idx) + CMP_W'(2);
  assign count_ext = CMP_W'(count);

  assign request.ready      = state == S_IDLE;
  assign result.valid       = out_valid;
  assign result.found       = out_found;
  assign result.position    = out_pos;
  assign result.entry_count = out_count;
  assign result.status      = out_status;

  assign stat.busy  = state != S_IDLE;
  assign stat.count = count;

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = idx;
    mem_req.wdata = rd_data;
    mem_req.raddr = idx;
    unique case (state)
      S_IDLE: begin
        mem_req.we    = accept && request.operation == OP_INSERT && has_room;
        mem_req.waddr = count[IDX_W-1:0];
        mem_req.wdata = request.key;
      end
      S_SCAN_CMP: begin
        mem_req.we    = match && op_reg == OP_UPDATE;
        mem_req.wdata = nv_reg;
      end
      S_SHIFT_RD: begin
        mem_req.raddr = IDX_W'(idx_plus1);
      end
      S_SHIFT_WR: begin
        mem_req.we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (result.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_reg     <= request.operation;
            key_reg    <= request.key;
            nv_reg     <= request.new_value;
            idx        <= '0;
            res_found  <= 1'b0;
            if (request.operation == OP_INSERT) begin
              if (has_room) begin
                res_pos    <= count[IDX_W-1:0];
                res_status <= ST_DONE;
                count      <= count + CNT_W'(1);
              end else begin
                res_pos    <= '0;
                res_status <= ST_FULL;
              end
              state <= S_FINISH;
            end else if (count == '0) begin
              res_pos    <= '0;
              res_status <= ST_MISSING;
              state      <= S_FINISH;
            end else begin
              res_pos    <= '0;
              res_status <= ST_DONE;
              state      <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (match) begin
            res_found <= 1'b1;
            res_pos   <= idx;
            if (op_reg == OP_DELETE && idx_plus1 < count_ext) begin
              state <= S_SHIFT_RD;
            end else begin
              if (op_reg == OP_DELETE) begin
                count <= count - CNT_W'(1);
              end
              state <= S_FINISH;
            end
          end else if (idx_plus1 == count_ext) begin
            res_status <= ST_MISSING;
            state      <= S_FINISH;
          end else begin
            idx   <= IDX_W'(idx_plus1);
            state <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx <= IDX_W'(idx_plus1);
          if (idx_plus2 < count_ext) begin
            state <= S_SHIFT_RD;
          end else begin
            count <= count - CNT_W'(1);
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_found  <= res_found;
            out_pos    <= POS_W'(res_pos);
            out_count  <= ENTRY_COUNT_W'(count);
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/unordered_list_table_top.sv =====
// top level of the unordered list table
//
//   channel   dir   handshake      payload
//   request   in    valid/ready    operation, key, new_value
//   result    out   valid/ready    found, position, entry_count, status
//
// insert writes the key at the end of the list and goes straight to the result; search,
// update and delete scan the entries in order, and delete then moves each later entry down.
// the entry memory has a single registered read port: a step reads, then compares or writes.
// synchronous reset clears the count and the result register; entries need no clearing.
// a request is taken while a finished result still waits; a stalled result holds the sequencer.
`default_nettype none

`include "assert_macros.svh"

module unordered_list_table_top (
  input  wire logic clk,
  input  wire logic rst,
  ult_req_if.sink   request,
  ult_res_if.source result
);
  import ult_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rd_data;
  seq_stat_t         stat;

  ult_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .rd_data (rd_data),
    .mem_req (mem_req),
    .stat    (stat)
  );

  ult_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  `ULT_ASSERT(a_count_bound, clk, rst, stat.count <= CNT_W'(CAPACITY), "count above capacity")
  `ULT_ASSERT_NEXT(a_busy_after_req, clk, rst, request.valid && request.ready, stat.busy && !request.ready, "ready right after request")
  `ULT_ASSERT(a_found_done, clk, rst, !(result.valid && result.found) || result.status == ST_DONE, "found with bad status")
  `ULT_ASSERT(a_full_count, clk, rst, !(result.valid && result.status == ST_FULL) || result.entry_count == ENTRY_COUNT_W'(CAPACITY), "full status below capacity")

endmodule

`default_nettype wire
